// File: design/cdis_pkg.sv
// Shared types, constants and codes for the column depth integral search block.
package cdis_pkg;
    localparam int MaxRows   = 64;
    localparam int FracBits  = 16;
    localparam int RowW      = $clog2(MaxRows);
    localparam int CntW      = RowW + 1;
    localparam int QW        = FracBits + 1;
    localparam int SumW      = 38;
    localparam int HgtW      = 22;
    localparam int DivNW     = SumW;
    localparam int DivDW     = HgtW;
    localparam int DivCntW   = $clog2(DivNW + 1);

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_FIND = 2'd1,
        CMD_EVAL = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_TARGET  = 3'd3,
        ST_ELEV    = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        first_block;
        logic [15:0] value;
        logic [15:0] thickness;
        logic [21:0] column_height;
        logic [16:0] target;
        logic [6:0]  elevation_block;
        logic [16:0] elevation_fraction;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] depth_value;
        logic [5:0]  row_index;
        logic [6:0]  block_index;
        logic [16:0] block_fraction;
        logic [2:0]  status;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_LD_MUL, S_LD_DIV, S_LD_WAIT, S_LD_DONE,
        S_FD_RDLAST, S_FD_CHK, S_FD_GUESS, S_FD_GWAIT, S_FD_RDB, S_FD_RDT,
        S_FD_CMP, S_FD_FDIV, S_FD_FWAIT,
        S_EV_RDB, S_EV_RDT, S_EV_MUL, S_EV_DONE, S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef enum logic [4:0] {
        OP_NOP, OP_CAPTURE, OP_LD_CLEAR, OP_LD_MUL, OP_LD_DIVSTART, OP_LD_STORE,
        OP_FD_INIT, OP_FD_GSTART, OP_FD_GTAKE, OP_FD_RDB, OP_FD_RDT,
        OP_FD_NARROW, OP_FD_FSTART, OP_FD_FTAKE, OP_FD_FLAT,
        OP_EV_RDB, OP_EV_RDT, OP_EV_MUL, OP_EV_TAKE, OP_ERROR, OP_RDLAST,
        OP_FD_HIT1, OP_ZERO
    } t_op;

    typedef struct packed {
        t_op      op;
        t_status  err;
    } t_ctl;

    typedef struct packed {
        logic cmd_load;
        logic cmd_find;
        logic cmd_eval;
        logic height_zero;
        logic full;
        logic empty;
        logic tgt_bad;
        logic elev_bad;
        logic elev_last;
        logic div_busy;
        logic flat;
        logic gt_bot;
        logic lt_top;
        logic top_gt_bot;
        logic cur_zero;
        logic iter_done;
        logic frac_trivial;
    } t_sts;
endpackage

// File: design/cdis_if.sv
// Valid/ready channel interface carrying one item.
interface cdis_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/cdis_ram.sv
// Generic single-port RAM with registered read.
module cdis_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: design/cdis_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module cdis_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cdis_pkg::DivNW-1:0] i_num,
    input  logic [cdis_pkg::DivDW-1:0] i_den,
    output logic                     o_busy,
    output logic [cdis_pkg::DivNW-1:0] o_quo
);
    import cdis_pkg::*;
    logic [DivNW-1:0]   r_quo, n_quo;
    logic [DivDW:0]     r_rem, n_rem;
    logic [DivDW-1:0]   r_den;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic [DivDW+1:0]   w_try;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        w_try = {r_rem, r_quo[DivNW-1]} - {2'b00, r_den};
        if (i_start) begin
            n_quo = i_num;
            n_rem = '0;
            n_cnt = DivCntW'(DivNW);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!w_try[DivDW+1]) begin
                n_rem = w_try[DivDW:0];
                n_quo = {r_quo[DivNW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DivDW-1:0], r_quo[DivNW-1]};
                n_quo = {r_quo[DivNW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end
    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule

// File: design/cdis_dp.sv
// Datapath: column state, row store, shared divider and search registers.
module cdis_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdis_pkg::t_in_item  i_item,
    input  cdis_pkg::t_ctl      i_ctl,
    output cdis_pkg::t_sts      o_sts,
    output cdis_pkg::t_out_item o_res
);
    import cdis_pkg::*;
    localparam logic [QW-1:0] OneQ = QW'(1) << FracBits;

    t_in_item         r_item;
    logic [CntW-1:0]  r_rows;
    logic [SumW-1:0]  r_sum;
    logic [HgtW-1:0]  r_hgt;
    logic [SumW:0]    r_acc;
    t_out_item        r_res;
    logic [RowW-1:0]  r_top, r_bot, r_cur;
    logic [QW-1:0]    r_top_val, r_bot_val, r_cb, r_ct;
    logic             r_top_ovf;   // top moved past the last row
    logic [CntW-1:0]  r_iter;
    logic             r_div_go;
    logic [DivNW-1:0] r_div_num;
    logic [DivDW-1:0] r_div_den;

    logic             w_we;
    logic [RowW-1:0]  w_addr;
    logic [QW-1:0]    w_rd, w_wd;
    logic             w_busy;
    logic [DivNW-1:0] w_quo;
    logic [QW-1:0]    w_q;
    logic [RowW:0]    w_g;
    logic [RowW-1:0]  w_span;
    logic [CntW-1:0]  w_last;
    logic [QW+CntW-1:0]     w_gprod;
    logic [2*FracBits-1:0]  w_mul;

    cdis_ram #(.Width(QW), .Depth(MaxRows)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd)
    );

    cdis_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_div_num), .i_den(r_div_den), .o_busy(w_busy), .o_quo(w_quo)
    );

    assign w_last  = r_rows - 1'b1;
    assign w_q     = (w_quo > DivNW'(OneQ)) ? OneQ : w_quo[QW-1:0];
    assign w_span  = r_bot - r_top;
    assign w_g     = (w_quo > DivNW'(w_span)) ? {1'b0, w_span} : w_quo[RowW:0];
    // guess numerator: (span + 1) * (target - top value)
    assign w_gprod = ((QW+CntW)'(w_span) + 1'b1)
                     * (QW+CntW)'(r_item.target - r_top_val);
    assign w_mul   = {16'd0, r_item.value} * {16'd0, r_item.thickness};

    always_comb begin
        w_we   = 1'b0;
        w_wd   = w_q;
        w_addr = r_cur;
        unique case (i_ctl.op)
            OP_LD_STORE: begin
                w_we   = 1'b1;
                w_addr = r_rows[RowW-1:0];
            end
            OP_RDLAST: w_addr = w_last[RowW-1:0];
            OP_FD_RDB: w_addr = r_cur;
            OP_FD_RDT: w_addr = r_cur - 1'b1;
            OP_EV_RDB: w_addr = r_item.elevation_block[RowW-1:0];
            OP_EV_RDT: w_addr = r_item.elevation_block[RowW-1:0] - 1'b1;
            default: w_addr = r_cur;
        endcase
    end

    always_comb begin
        o_sts.cmd_load     = (r_item.cmd == CMD_LOAD);
        o_sts.cmd_find     = (r_item.cmd == CMD_FIND);
        o_sts.cmd_eval     = (r_item.cmd == CMD_EVAL);
        o_sts.height_zero  = (r_hgt == '0);
        o_sts.full         = (r_rows == CntW'(MaxRows));
        o_sts.empty        = (r_rows == '0);
        o_sts.tgt_bad      = (r_item.target > OneQ) || (r_item.target > r_bot_val);
        o_sts.elev_bad     = (CntW'(r_item.elevation_block) > r_rows)
                             || (r_item.elevation_block > 7'(MaxRows))
                             || (r_item.elevation_fraction > OneQ);
        o_sts.elev_last    = (CntW'(r_item.elevation_block) == r_rows);
        o_sts.div_busy     = w_busy || r_div_go;
        o_sts.flat         = (r_bot_val <= r_top_val);
        o_sts.gt_bot       = (r_cb < r_item.target);
        o_sts.lt_top       = (r_item.target < r_ct);
        o_sts.top_gt_bot   = r_top_ovf || (r_top > r_bot);
        o_sts.cur_zero     = (r_cur == '0);
        o_sts.iter_done    = (r_iter > CntW'(MaxRows));
        o_sts.frac_trivial = (r_cb == r_ct) || ((r_item.target - r_ct) >= (r_cb - r_ct));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_sum  <= '0;
            r_hgt  <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (i_ctl.op == OP_LD_DIVSTART) || (i_ctl.op == OP_FD_GSTART)
                        || (i_ctl.op == OP_FD_FSTART);
            unique case (i_ctl.op)
                OP_CAPTURE: begin
                    r_item <= i_item;
                    r_res  <= '{kind: i_item.cmd, default: '0};
                end
                OP_LD_CLEAR: begin
                    if (r_item.first_block) begin
                        r_rows <= '0;
                        r_sum  <= '0;
                        r_hgt  <= r_item.column_height;
                    end
                end
                OP_LD_MUL: r_acc <= {1'b0, r_sum} + (SumW+1)'(w_mul);
                OP_LD_DIVSTART: begin
                    r_sum     <= r_acc[SumW] ? '1 : r_acc[SumW-1:0];
                    r_div_num <= r_acc[SumW] ? '1 : r_acc[SumW-1:0];
                    r_div_den <= r_hgt;
                end
                OP_LD_STORE: begin
                    r_rows <= r_rows + 1'b1;
                    r_res.depth_value <= w_q;
                    r_res.row_index   <= r_rows[RowW-1:0];
                end
                OP_RDLAST: r_cur <= w_last[RowW-1:0];
                OP_FD_INIT: begin
                    r_top     <= '0;
                    r_top_val <= '0;
                    r_top_ovf <= 1'b0;
                    r_bot     <= w_last[RowW-1:0];
                    r_bot_val <= w_rd;
                    r_iter    <= '0;
                end
                OP_FD_GSTART: begin
                    r_iter    <= r_iter + 1'b1;
                    r_div_num <= DivNW'(w_gprod);
                    r_div_den <= DivDW'(r_bot_val - r_top_val);
                end
                OP_FD_FLAT: begin
                    r_iter <= r_iter + 1'b1;
                    r_cur  <= r_top;
                end
                OP_FD_GTAKE: r_cur <= r_top + w_g[RowW-1:0];
                OP_FD_RDB: ;
                OP_FD_RDT: r_cb <= w_rd;
                OP_FD_NARROW: begin
                    if (r_cur == '0) r_ct <= '0;
                    else r_ct <= w_rd;
                end
                OP_FD_HIT1: begin
                    if (r_cb < r_item.target) begin
                        if (r_cur == RowW'(MaxRows - 1)) r_top_ovf <= 1'b1;
                        r_top <= r_cur + 1'b1;
                        r_top_val <= r_cb;
                    end else begin
                        r_bot <= r_cur - 1'b1;
                        r_bot_val <= r_ct;
                    end
                end
                OP_FD_FSTART: begin
                    r_div_num <= DivNW'({r_item.target - r_ct, FracBits'(0)});
                    r_div_den <= DivDW'(r_cb - r_ct);
                end
                OP_FD_FTAKE: begin
                    r_res.block_index <= 7'(r_cur);
                    if (r_cb == r_ct) r_res.block_fraction <= '0;
                    else if ((r_item.target - r_ct) >= (r_cb - r_ct))
                        r_res.block_fraction <= OneQ;
                    else r_res.block_fraction <= w_quo[QW-1:0];
                end
                OP_EV_RDB: ;
                OP_EV_RDT: r_cb <= w_rd;
                OP_EV_MUL: begin
                    r_ct <= (r_item.elevation_block == '0) ? '0 : w_rd;
                end
                OP_EV_TAKE: begin
                    if (o_sts.elev_last) r_res.depth_value <= w_rd;
                    else if (r_item.elevation_fraction >= OneQ) r_res.depth_value <= r_cb;
                    else if (r_cb <= r_ct) r_res.depth_value <= r_ct;
                    else r_res.depth_value <= r_ct + QW'(((2*QW)'(r_cb - r_ct)
                        * (2*QW)'(r_item.elevation_fraction)) >> FracBits);
                end
                OP_ERROR: begin
                    r_res.depth_value    <= '0;
                    r_res.row_index      <= '0;
                    r_res.block_index    <= '0;
                    r_res.block_fraction <= '0;
                    r_res.status         <= i_ctl.err;
                end
                OP_ZERO: ;
                default: ;
            endcase
        end
    end
    assign o_res = r_res;
endmodule

// File: design/cdis_ctrl.sv
// Controller state machine sequencing load, find and eval items.
module cdis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cdis_pkg::t_sts i_sts,
    output cdis_pkg::t_ctl o_ctl
);
    import cdis_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl.op    = OP_NOP;
        o_ctl.err   = ST_OK;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.cmd_load) begin
                    n_state = S_LD_MUL;
                end else if (i_sts.cmd_find || i_sts.cmd_eval) begin
                    if (i_sts.empty) begin
                        o_ctl.op = OP_ERROR; o_ctl.err = ST_EMPTY; n_state = S_OUT;
                    end else begin
                        o_ctl.op = OP_RDLAST;
                        n_state  = i_sts.cmd_find ? S_FD_RDLAST : S_EV_RDB;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LD_MUL: begin
                o_ctl.op = OP_LD_CLEAR;
                n_state  = S_LD_DIV;
            end
            S_LD_DIV: begin
                if (i_sts.height_zero) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_EMPTY; n_state = S_OUT;
                end else if (i_sts.full) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_FULL; n_state = S_OUT;
                end else begin
                    o_ctl.op = OP_LD_MUL; n_state = S_LD_WAIT;
                end
            end
            S_LD_WAIT: begin
                o_ctl.op = OP_LD_DIVSTART;
                n_state  = S_LD_DONE;
            end
            S_LD_DONE: begin
                if (!i_sts.div_busy) begin
                    o_ctl.op = OP_LD_STORE; n_state = S_OUT;
                end
            end
            S_FD_RDLAST: n_state = S_FD_CHK;
            S_FD_CHK: begin
                o_ctl.op = OP_FD_INIT;
                n_state  = S_FD_GUESS;
            end
            S_FD_GUESS: begin
                if (i_sts.tgt_bad) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_TARGET; n_state = S_OUT;
                end else if (i_sts.top_gt_bot || i_sts.iter_done) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_TARGET; n_state = S_OUT;
                end else if (i_sts.flat) begin
                    o_ctl.op = OP_FD_FLAT; n_state = S_FD_RDB;
                end else begin
                    o_ctl.op = OP_FD_GSTART; n_state = S_FD_GWAIT;
                end
            end
            S_FD_GWAIT: begin
                if (!i_sts.div_busy) begin
                    o_ctl.op = OP_FD_GTAKE; n_state = S_FD_RDB;
                end
            end
            S_FD_RDB: begin
                o_ctl.op = OP_FD_RDB; n_state = S_FD_RDT;
            end
            S_FD_RDT: begin
                o_ctl.op = OP_FD_RDT; n_state = S_FD_CMP;
            end
            S_FD_CMP: begin
                o_ctl.op = OP_FD_NARROW; n_state = S_FD_FDIV;
            end
            S_FD_FDIV: begin
                if (i_sts.gt_bot || (i_sts.lt_top && !i_sts.cur_zero)) begin
                    o_ctl.op = OP_FD_HIT1; n_state = S_FD_GUESS;
                end else if (i_sts.lt_top) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_TARGET; n_state = S_OUT;
                end else begin
                    o_ctl.op = OP_FD_FSTART; n_state = S_FD_FWAIT;
                end
            end
            S_FD_FWAIT: begin
                if (!i_sts.div_busy) begin
                    o_ctl.op = OP_FD_FTAKE; n_state = S_OUT;
                end
            end
            S_EV_RDB: begin
                if (i_sts.elev_bad) begin
                    o_ctl.op = OP_ERROR; o_ctl.err = ST_ELEV; n_state = S_OUT;
                end else begin
                    o_ctl.op = OP_EV_RDB; n_state = S_EV_RDT;
                end
            end
            S_EV_RDT: begin
                o_ctl.op = OP_EV_RDT; n_state = S_EV_MUL;
            end
            S_EV_MUL: begin
                o_ctl.op = OP_EV_MUL; n_state = S_EV_DONE;
            end
            S_EV_DONE: begin
                // last stored row is on the read port here
                o_ctl.op = OP_EV_TAKE;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: design/column_depth_integral_search.sv
// Top level of the column depth integral search block.
//  channel | dir | payload              | handshake
//  in_if   | in  | cmd, value, target.. | valid/ready
//  out_if  | out | kind, depth_value..  | valid/ready
// One item at a time. Load: the sum goes through the 38-step divider before the store.
// Find: reads the last row and sets up, then each search step runs the guess division
// and reads two rows (a flat step skips the division); a hit divides for the fraction.
// Reset clears row count, sum and height; the row store is not cleared.
// A result waits in its register until taken; no new item meanwhile.
module column_depth_integral_search (
    input  logic i_clk,
    input  logic i_rst_n,
    cdis_if.sink   in_if,
    cdis_if.source out_if
);
    import cdis_pkg::*;
    t_ctl w_ctl;
    t_sts w_sts;

    cdis_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .o_in_ready(in_if.ready),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready),
        .i_sts(w_sts), .o_ctl(w_ctl)
    );

    cdis_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(in_if.data),
        .i_ctl(w_ctl), .o_sts(w_sts), .o_res(out_if.data)
    );
endmodule

// File: design/cdis_chk.sv
// Port-level checker for the column depth integral search block.
module cdis_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_kind,
    input logic [2:0] out_status
);
    import cdis_pkg::*;
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("result dropped");
    a_none_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_kind == CMD_NONE |-> out_status == ST_OK)
        else $error("bad status on unknown command");
    a_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second accept");
endmodule

bind column_depth_integral_search cdis_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_kind(out_if.data.kind), .out_status(out_if.data.status)
);

// File: tb/sv/column_depth_integral_search_test.sv
// Testbench for the column depth integral search block: directed and random items, checked against a predictor.
`timescale 1ns / 100ps
module column_depth_integral_search_test;
    import cdis_pkg::*;

    localparam logic [16:0] ONE_Q = 17'h10000;
    localparam logic [37:0] SUM_SAT = {38{1'b1}};

    logic i_clk;
    logic i_rst_n;

    cdis_if #(.T(t_in_item))  in_if ();
    cdis_if #(.T(t_out_item)) out_if ();

    column_depth_integral_search uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_if.sink),
        .out_if  (out_if.source)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic [16:0] col_rows [MaxRows];
    int unsigned col_count;
    logic [37:0] col_sum;
    logic [21:0] col_height;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int mismatches;
    bit stim_done;
    bit hold_sender;

    function automatic t_out_item blank_result(t_cmd k, t_status s);
        t_out_item r;
        r = '0;
        r.kind = k;
        r.status = s;
        return r;
    endfunction

    function automatic logic [16:0] row_above(int unsigned r);
        return (r == 0) ? 17'd0 : col_rows[r - 1];
    endfunction

    function automatic t_out_item predict_column(t_in_item it);
        t_out_item r;
        logic [63:0] acc, q, g, t, top_val, bot_val, cb, ct, d, n, f, b, fr, lo, hi;
        int top, bot, cur, iter;
        r = '0;
        case (t_cmd'(it.cmd))
            CMD_LOAD: begin
                if (it.first_block) begin
                    col_count = 0;
                    col_sum = '0;
                    col_height = it.column_height;
                end
                if (col_height == 0) return blank_result(CMD_LOAD, ST_EMPTY);
                if (col_count >= MaxRows) return blank_result(CMD_LOAD, ST_FULL);
                acc = 64'(col_sum) + 64'(it.value) * 64'(it.thickness);
                if (acc > 64'(SUM_SAT)) acc = 64'(SUM_SAT);
                col_sum = acc[37:0];
                q = acc / 64'(col_height);
                if (q > 64'(ONE_Q)) q = 64'(ONE_Q);
                col_rows[col_count] = q[16:0];
                r = blank_result(CMD_LOAD, ST_OK);
                r.depth_value = q[16:0];
                r.row_index = col_count[5:0];
                col_count++;
            end
            CMD_FIND: begin
                t = 64'(it.target);
                if (col_count == 0) return blank_result(CMD_FIND, ST_EMPTY);
                if (t > 64'(ONE_Q) || t > 64'(col_rows[col_count - 1]))
                    return blank_result(CMD_FIND, ST_TARGET);
                top = 0; top_val = 0;
                bot = col_count - 1; bot_val = 64'(col_rows[bot]);
                for (iter = 0; iter <= MaxRows && top <= bot; iter++) begin
                    if (bot_val <= top_val) begin
                        cur = top;
                    end else begin
                        g = (64'(bot - top + 1) * (t - top_val)) / (bot_val - top_val);
                        if (g > 64'(bot - top)) g = 64'(bot - top);
                        cur = top + int'(g);
                    end
                    cb = 64'(col_rows[cur]);
                    ct = 64'(row_above(cur));
                    if (cb < t) begin
                        top = cur + 1; top_val = cb;
                    end else if (t < ct) begin
                        if (cur == 0) break;
                        bot = cur - 1; bot_val = ct;
                    end else begin
                        d = cb - ct; n = t - ct;
                        if (d == 0) f = 0;
                        else if (n >= d) f = 64'(ONE_Q);
                        else f = (n << FracBits) / d;
                        r = blank_result(CMD_FIND, ST_OK);
                        r.block_index = cur[6:0];
                        r.block_fraction = f[16:0];
                        return r;
                    end
                end
                r = blank_result(CMD_FIND, ST_TARGET);
            end
            CMD_EVAL: begin
                b = 64'(it.elevation_block);
                fr = 64'(it.elevation_fraction);
                if (col_count == 0) return blank_result(CMD_EVAL, ST_EMPTY);
                if (b > 64'(col_count) || fr > 64'(ONE_Q))
                    return blank_result(CMD_EVAL, ST_ELEV);
                r = blank_result(CMD_EVAL, ST_OK);
                if (b == 64'(col_count)) begin
                    r.depth_value = col_rows[col_count - 1];
                end else begin
                    lo = 64'(row_above(int'(b)));
                    hi = 64'(col_rows[b]);
                    if (fr >= 64'(ONE_Q)) q = hi;
                    else if (hi <= lo) q = lo;
                    else q = lo + (((hi - lo) * fr) >> FracBits);
                    r.depth_value = q[16:0];
                end
            end
            default: r = blank_result(CMD_NONE, ST_OK);
        endcase
        return r;
    endfunction

    function automatic t_in_item rand_item(t_cmd c);
        t_in_item it;
        it.cmd = c;
        it.first_block = 1'($urandom_range(0, 1));
        it.value = 16'($urandom);
        it.thickness = 16'($urandom);
        it.column_height = 22'($urandom);
        it.target = 17'($urandom_range(0, 131071));
        it.elevation_block = 7'($urandom);
        it.elevation_fraction = 17'($urandom_range(0, 131071));
        return it;
    endfunction

    function automatic t_in_item load_item(bit first, logic [15:0] v, logic [15:0] dz,
                                           logic [21:0] h);
        t_in_item it;
        it = rand_item(CMD_LOAD);
        it.first_block = first;
        it.value = v;
        it.thickness = dz;
        it.column_height = h;
        return it;
    endfunction

    // mostly in-range finds and evals, with some noise
    function automatic t_in_item query_item(t_cmd c, int unsigned rows);
        t_in_item it;
        it = rand_item(c);
        if ($urandom_range(0, 9) != 0) begin
            it.target = 17'((rows > 0 && $urandom_range(0, 1)) ?
                            $urandom_range(0, col_rows[rows - 1]) : $urandom_range(0, 65536));
            it.elevation_block = 7'($urandom_range(0, rows));
            it.elevation_fraction = $urandom_range(0, 3) == 0 ?
                                    ($urandom_range(0, 1) ? 17'd65536 : 17'd0) :
                                    17'($urandom_range(0, 65536));
        end
        return it;
    endfunction

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_sender) begin
                in_if.data <= pending_items.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            expected_results.push_back(predict_column(in_if.data));
    end

    // receiver stall pattern and result check
    int stall_phase;
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            out_if.ready <= (stall_phase % 512 < 200) ? 1'b1 :
                            ((stall_phase % 7) != 3 && $urandom_range(0, 3) != 0);
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_if.data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_if.data !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, out_if.data);
                    end
                end
            end
        end
    end

    initial begin
        #500_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned rows;
        int k, n;
        t_in_item it;
        bit paused;
        mismatches = 0;
        stim_done = 0;
        hold_sender = 0;
        paused = 0;
        col_count = 0;
        col_sum = '0;
        col_height = '0;
        foreach (col_rows[i]) col_rows[i] = '0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty column, unknown command, zero height
        pending_items.push_back(query_item(CMD_FIND, 0));
        pending_items.push_back(query_item(CMD_EVAL, 0));
        it = rand_item(CMD_NONE);
        pending_items.push_back(it);
        pending_items.push_back(load_item(1'b1, 16'hFFFF, 16'hFFFF, 22'd0));
        // tiny height saturates depth
        pending_items.push_back(load_item(1'b1, 16'hFFFF, 16'hFFFF, 22'd1));
        for (k = 0; k < 4; k++)
            pending_items.push_back(load_item(1'b0, 16'hFFFF, 16'hFFFF, 22'd0));
        // flat rows then growth
        pending_items.push_back(load_item(1'b1, 16'd0, 16'd5, 22'h3FFFFF));
        pending_items.push_back(load_item(1'b0, 16'd0, 16'd5, 22'd0));
        pending_items.push_back(load_item(1'b0, 16'h8000, 16'd64, 22'd100));
        pending_items.push_back(load_item(1'b0, 16'hFFFF, 16'd40, 22'd0));
        it = query_item(CMD_FIND, 0); it.target = 17'd0; pending_items.push_back(it);
        it.target = 17'd65536; pending_items.push_back(it);
        it.target = 17'h1FFFF; pending_items.push_back(it);
        it = query_item(CMD_EVAL, 0); it.elevation_block = 7'd4;
        it.elevation_fraction = 17'd1234; pending_items.push_back(it);
        it.elevation_block = 7'd5; pending_items.push_back(it);
        it.elevation_block = 7'd0; it.elevation_fraction = 17'd65537;
        pending_items.push_back(it);
        it.elevation_fraction = 17'd65536; pending_items.push_back(it);
        it.elevation_block = 7'h7F; pending_items.push_back(it);
        // fill a column to overflow
        pending_items.push_back(load_item(1'b1, 16'd1, 16'd1, 22'h3FFFFF));
        for (k = 0; k < MaxRows; k++)
            pending_items.push_back(load_item(1'b0, 16'd3, 16'd7, 22'd0));

        // wait for drain before random part
        while (pending_items.size() > 0 || expected_results.size() > 0 || in_if.valid)
            @(posedge i_clk);

        // random: columns of random size with queries
        n = 0;
        while (n < 1500) begin
            rows = $urandom_range(1, $urandom_range(0, 7) == 0 ? MaxRows + 2 : 12);
            it = load_item(1'b1, 16'($urandom),
                           16'($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom),
                           $urandom_range(0, 15) == 0 ? 22'd0 :
                           22'($urandom_range(1, 4194303)));
            pending_items.push_back(it);
            for (k = 1; k < rows; k++) begin
                it = load_item($urandom_range(0, 19) == 0, 16'($urandom),
                               $urandom_range(0, 3) == 0 ? 16'($urandom) :
                               16'($urandom_range(0, 500)), 22'($urandom));
                pending_items.push_back(it);
            end
            // let loads finish so targets follow the stored column
            while (pending_items.size() > 0 || expected_results.size() > 0 || in_if.valid)
                @(posedge i_clk);
            n += rows;
            for (k = $urandom_range(2, 12); k > 0; k--) begin
                case ($urandom_range(0, 9))
                    0: pending_items.push_back(rand_item(CMD_NONE));
                    1, 2, 3, 4: pending_items.push_back(query_item(CMD_FIND, col_count));
                    default: pending_items.push_back(query_item(CMD_EVAL, col_count));
                endcase
                n++;
            end
            if (!paused || $urandom_range(0, 9) == 0) begin
                repeat (20) @(posedge i_clk);
                hold_sender = 1;
                paused = 1;
                while (expected_results.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
        end

        while (pending_items.size() > 0 || in_if.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
